>>> design/itc_pkg.sv
// itc_pkg: shared types and constants for the ipv4 transport checksum core
// no dependencies; imported by itc_acc and ipv4_transport_checksum_core
package itc_pkg;

   // frame layout
   localparam int unsigned EthHeaderBytes = 14;
   localparam logic [16:0] PosMax         = 17'h1FFFF;
   localparam logic [16:0] IpHdrStart     = 17'(EthHeaderBytes);
   localparam logic [16:0] IpHdrEnd       = 17'd34;
   localparam logic [16:0] ProtoPos       = 17'd23;
   localparam logic [16:0] AddrPos        = 17'd26;

   // checksum mode codes
   typedef enum logic {
      MODE_TRANSPORT = 1'b0,
      MODE_IP_HEADER = 1'b1
   } mode_type;

   // one result item
   typedef struct packed {
      logic        short_frame;
      logic [15:0] checksum;
   } result_type;

   // byte aligned into its half of a big-endian 16-bit word
   function automatic logic [31:0] word_part(input logic [7:0] data, input logic odd);
      word_part = odd ? {24'd0, data} : {16'd0, data, 8'd0};
   endfunction

endpackage

>>> design/ipv4_transport_checksum_core.sv
// ipv4_transport_checksum_core: ipv4 header / tcp-udp checksum over a byte stream
// depends on itc_pkg and itc_acc
//
// channel | dir | handshake            | payload
// req     | in  | req_tvalid/tready    | tdata: frame_byte, segment_length; tlast
// rsp     | out | rsp_tvalid/tready    | tdata: checksum; tuser: short_frame
// csr     | in  | csr_valid/ready      | csr_data: checksum_mode
//
// one byte per cycle while the input does not stall; each byte is held in the input register,
// then added into the accumulator; the frame's result is registered into the output
// register, or the skid, when the last byte advances out of the input register.
// synchronous reset clears the accumulator, mode and all valid flags.
// a two-entry result queue (output register plus skid) absorbs rsp stalls; input
// stalls only when the skid is full and a last byte waits.
module ipv4_transport_checksum_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] frame_byte, [23:8] segment_length
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] checksum
   output logic        rsp_tuser,   // [0] short_frame
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);
   import itc_pkg::*;

   mode_type    mode_ff;
   logic        stage_valid_ff, stage_valid_in;
   logic [7:0]  stage_byte_ff;
   logic        stage_last_ff;
   logic [15:0] stage_len_ff;
   logic        advance, push, pop, req_fire;
   result_type  acc_result;
   result_type  out_ff, out_in, skid_ff, skid_in;
   logic        out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   // mode register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_TRANSPORT;
      end else if (csr_valid) begin
         mode_ff <= mode_type'(csr_data);
      end
   end

   // input register stage
   assign advance        = stage_valid_ff && (!stage_last_ff || !skid_valid_ff);
   assign req_tready     = !stage_valid_ff || advance;
   assign req_fire       = req_tvalid && req_tready;
   assign stage_valid_in = req_fire ? 1'b1 : (advance ? 1'b0 : stage_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_byte_ff <= req_tdata[7:0];
         stage_len_ff  <= req_tdata[23:8];
         stage_last_ff <= req_tlast;
      end
   end

   // accumulator
   itc_acc u_acc (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .mode           (mode_ff),
      .frame_byte     (stage_byte_ff),
      .last_byte      (stage_last_ff),
      .segment_length (stage_len_ff),
      .result         (acc_result)
   );

   // result queue: output register plus skid
   assign push = advance && stage_last_ff;
   assign pop  = out_valid_ff && rsp_tready;

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = acc_result;
            out_valid_in = push;
         end
      end else if (push) begin
         skid_in       = acc_result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.checksum;
   assign rsp_tuser  = out_ff.short_frame;

`ifndef NO_ASSERTIONS
   // skid only fills behind a held output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a result while output register is empty");

   // a last byte never advances into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && stage_last_ff && skid_valid_ff) |-> (!advance && !req_tready))
      else $error("last byte advanced with full result queue");

   // after a finished frame, rsp_tvalid is high the next cycle
   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      push |=> rsp_tvalid)
      else $error("result not presented after frame end");
`endif

endmodule

>>> design/itc_acc.sv
// itc_acc: per-frame checksum accumulator, one byte per advance
// depends on itc_pkg
module itc_acc (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  itc_pkg::mode_type   mode,
   input  logic [7:0]          frame_byte,
   input  logic                last_byte,
   input  logic [15:0]         segment_length,
   output itc_pkg::result_type result
);
   import itc_pkg::*;

   logic        first_ff, first_in;
   logic [16:0] pos_ff, pos_in;
   logic [5:0]  ihl_ff, ihl_in;
   logic [15:0] seglen_ff, seglen_in;
   logic [31:0] sum_ff, sum_in;

   logic [16:0] pos_cur;
   logic [5:0]  ihl_cur, ihl_new;
   logic [15:0] seglen_cur;
   logic [31:0] sum_cur, sum_new, add_hdr, add_proto, add_addr, add_seg, total;
   logic [16:0] seg_start, seg_off;
   logic [17:0] need, need_seg, pos_next_len;
   logic [16:0] fold_a;
   logic [15:0] fold_b;

   // frame start view of the state
   always_comb begin
      pos_cur    = first_ff ? 17'd0 : pos_ff;
      ihl_cur    = first_ff ? 6'd0 : ihl_ff;
      seglen_cur = first_ff ? segment_length : seglen_ff;
      sum_cur    = first_ff ? 32'd0 : sum_ff;
      ihl_new    = (pos_cur == IpHdrStart) ? {frame_byte[3:0], 2'b00} : ihl_cur;
   end

   // contributions of this byte; word half follows byte parity since all
   // region starts are even
   always_comb begin
      seg_start = IpHdrStart + {11'd0, ihl_new};
      seg_off   = pos_cur - seg_start;
      add_hdr   = 32'd0;
      add_proto = 32'd0;
      add_addr  = 32'd0;
      add_seg   = 32'd0;
      if (mode == MODE_IP_HEADER) begin
         if (pos_cur >= IpHdrStart && pos_cur < IpHdrEnd)
            add_hdr = word_part(frame_byte, pos_cur[0]);
      end else begin
         if (pos_cur == ProtoPos)
            add_proto = {24'd0, frame_byte};
         if (pos_cur >= AddrPos && pos_cur < IpHdrEnd)
            add_addr = word_part(frame_byte, pos_cur[0]);
         if (pos_cur >= seg_start && seg_off < {1'b0, seglen_cur})
            add_seg = word_part(frame_byte, pos_cur[0]);
      end
      sum_new = sum_cur + add_hdr + add_proto + add_addr + add_seg;
   end

   // end of frame: pseudo-header length (transport mode), short check, fold and invert
   always_comb begin
      need_seg     = {1'b0, seg_start} + {2'd0, seglen_cur};
      pos_next_len = {1'b0, pos_cur} + 18'd1;
      if (mode == MODE_IP_HEADER) begin
         total = sum_new;
         need  = {1'b0, IpHdrEnd};
      end else begin
         total = sum_new + {16'd0, seglen_cur};
         need  = (need_seg < {1'b0, IpHdrEnd}) ? {1'b0, IpHdrEnd} : need_seg;
      end
      fold_a             = {1'b0, total[15:0]} + {1'b0, total[31:16]};
      fold_b             = fold_a[15:0] + {15'd0, fold_a[16]};
      result.checksum    = ~fold_b;
      result.short_frame = pos_next_len < need;
   end

   // next state
   always_comb begin
      first_in  = first_ff;
      pos_in    = pos_ff;
      ihl_in    = ihl_ff;
      seglen_in = seglen_ff;
      sum_in    = sum_ff;
      if (advance) begin
         seglen_in = seglen_cur;
         if (last_byte) begin
            first_in = 1'b1;
            pos_in   = 17'd0;
            ihl_in   = 6'd0;
            sum_in   = 32'd0;
         end else begin
            first_in = 1'b0;
            pos_in   = (pos_cur < PosMax) ? pos_cur + 17'd1 : pos_cur;
            ihl_in   = ihl_new;
            sum_in   = sum_new;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= 1'b1;
         pos_ff    <= 17'd0;
         ihl_ff    <= 6'd0;
         seglen_ff <= 16'd0;
         sum_ff    <= 32'd0;
      end else begin
         first_ff  <= first_in;
         pos_ff    <= pos_in;
         ihl_ff    <= ihl_in;
         seglen_ff <= seglen_in;
         sum_ff    <= sum_in;
      end
   end

endmodule
